FILE: rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared widths, constants and the stage-1 item type of the block linear
// resampler.
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int FRAC_W     = 11;
	localparam int OUT_W      = 27;
	localparam int BLOCK_W    = 14;
	localparam int POS_W      = 25;
	localparam int IDX_W      = 12;
	localparam int ACC_W      = SAMPLE_W + FRAC_W + 2;
	localparam int S_TDATA_W  = 2 * SAMPLE_W;
	localparam int M_TDATA_W  = ((2 * OUT_W + 7) / 8) * 8;

	localparam logic [BLOCK_W-1:0] MIN_BLOCK   = 14'd2048;
	localparam logic [BLOCK_W-1:0] RESET_BLOCK = 14'd2500;
	localparam logic [IDX_W-1:0]   LAST_INDEX  = 12'd2047;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] prev_i;
		logic signed [SAMPLE_W-1:0] prev_q;
		logic signed [SAMPLE_W-1:0] cur_i;
		logic signed [SAMPLE_W-1:0] cur_q;
		logic [FRAC_W-1:0]          frac;
		logic                       last;
	} blr_item_t;

endpackage

FILE: rtl/block_linear_resampler.sv
// ----------------------------------------------------------------------------
// block_linear_resampler
// Linear interpolation resampler: N input I/Q samples per block to 2048
// output samples per block.
// ----------------------------------------------------------------------------
// a result is held in the stage-1 register (counter stage), then in the output
// register (multiply stage), which drives m_tvalid; back-pressure can stall either
// throughput: one input sample per cycle while the stage-1 item is not held by
// back-pressure and no register write is pending, at most one result per sample
// reset: arst_n clears the counters, history and valid flags; in_per_block
// returns to 2500 and the first sample after reset only primes the history
module block_linear_resampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [blr_pkg::BLOCK_W-1:0]       cfg_data,   // in_per_block
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [blr_pkg::S_TDATA_W-1:0]     s_tdata,    // i_sample, q_sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [blr_pkg::M_TDATA_W-1:0]     m_tdata,    // i_out, q_out, zero pad
	output logic                              m_tlast     // block_last
);

	logic               item_valid;
	logic               item_ready;
	blr_pkg::blr_item_t item;

	assign cfg_ready = 1'b1;

	blr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	blr_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: rtl/blr_ctrl.sv
// ----------------------------------------------------------------------------
// blr_ctrl
// Input side: block position counters, output scheduling and the stage-1
// register that holds the two samples and the fraction of each output.
// ----------------------------------------------------------------------------
module blr_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [blr_pkg::BLOCK_W-1:0]         cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [blr_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic                                item_valid,
	input  logic                                item_ready,
	output blr_pkg::blr_item_t                  item
);

	logic [blr_pkg::BLOCK_W-1:0]         in_per_block_q;
	logic signed [blr_pkg::SAMPLE_W-1:0] prev_i_q;
	logic signed [blr_pkg::SAMPLE_W-1:0] prev_q_q;
	logic                                primed_q;
	logic [blr_pkg::BLOCK_W-1:0]         sample_pos_q;
	logic [blr_pkg::IDX_W-1:0]           out_index_q;
	logic [blr_pkg::POS_W-1:0]           out_pos_q;

	logic                                item_valid_s1;
	blr_pkg::blr_item_t                  item_s1;

	logic signed [blr_pkg::SAMPLE_W-1:0] cur_i;
	logic signed [blr_pkg::SAMPLE_W-1:0] cur_q;
	logic [blr_pkg::BLOCK_W-1:0]         block_len;
	logic [blr_pkg::BLOCK_W-1:0]         sample_pos_nxt;
	logic [blr_pkg::BLOCK_W:0]           base_plus1;
	logic                                hit;
	logic                                is_last;
	logic                                accept;

	assign cur_i = s_tdata[blr_pkg::SAMPLE_W-1:0];
	assign cur_q = s_tdata[2*blr_pkg::SAMPLE_W-1:blr_pkg::SAMPLE_W];

	assign block_len = (in_per_block_q < blr_pkg::MIN_BLOCK) ? blr_pkg::MIN_BLOCK
		: in_per_block_q;

	assign sample_pos_nxt = sample_pos_q + 1'b1;
	// base sample index of the next output, plus one, without wrap
	assign base_plus1 = {1'b0, out_pos_q[blr_pkg::POS_W-1:blr_pkg::FRAC_W]} + 1'b1;
	assign hit        = primed_q && (base_plus1 == {1'b0, sample_pos_nxt});
	assign is_last    = (out_index_q == blr_pkg::LAST_INDEX);

	// no sample transaction in the cycle of a register write
	assign s_tready   = (!item_valid_s1 || item_ready) && !cfg_valid;
	assign accept     = s_tvalid && s_tready;
	assign item_valid = item_valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_per_block_q <= blr_pkg::RESET_BLOCK;
			prev_i_q       <= '0;
			prev_q_q       <= '0;
			primed_q       <= 1'b0;
			sample_pos_q   <= '0;
			out_index_q    <= '0;
			out_pos_q      <= '0;
		end else if (cfg_valid) begin
			in_per_block_q <= cfg_data;
			sample_pos_q   <= '0;
			out_index_q    <= '0;
			out_pos_q      <= '0;
		end else if (accept) begin
			prev_i_q <= cur_i;
			prev_q_q <= cur_q;
			if (!primed_q) begin
				primed_q     <= 1'b1;
				sample_pos_q <= '0;
				out_index_q  <= '0;
				out_pos_q    <= '0;
			end else if (sample_pos_nxt >= block_len) begin
				// block end: this sample is sample 0 of the next block
				sample_pos_q <= '0;
				out_index_q  <= '0;
				out_pos_q    <= '0;
			end else begin
				sample_pos_q <= sample_pos_nxt;
				if (hit) begin
					if (is_last) begin
						out_index_q <= '0;
						out_pos_q   <= '0;
					end else begin
						out_index_q <= out_index_q + 1'b1;
						out_pos_q   <= out_pos_q + blr_pkg::POS_W'(block_len);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= hit;
		end else if (item_ready) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			item_s1.prev_i <= prev_i_q;
			item_s1.prev_q <= prev_q_q;
			item_s1.cur_i  <= cur_i;
			item_s1.cur_q  <= cur_q;
			item_s1.frac   <= out_pos_q[blr_pkg::FRAC_W-1:0];
			item_s1.last   <= is_last;
		end
	end

	// output position is zero whenever the output index is zero
	a_pos_tracks_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_index_q == '0) |-> (out_pos_q == '0))
		else $error("output position nonzero at output index zero");

	// nothing is scheduled before the first sample
	a_unprimed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> (sample_pos_q == '0 && out_index_q == '0 && !item_valid_s1))
		else $error("counters moved before priming");

	// a stalled stage-1 item is neither dropped nor changed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && !item_ready) |=> (item_valid_s1 && $stable(item_s1)))
		else $error("stage-1 item lost under stall");

endmodule

FILE: rtl/blr_interp.sv
// ----------------------------------------------------------------------------
// blr_interp
// Interpolation stage: prev*2048 + (cur-prev)*frac per channel, one
// multiplier each, into the output register.
// ----------------------------------------------------------------------------
module blr_interp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  blr_pkg::blr_item_t                item,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [blr_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                              m_tlast
);

	logic signed [blr_pkg::SAMPLE_W:0]   diff_i;
	logic signed [blr_pkg::SAMPLE_W:0]   diff_q;
	logic signed [blr_pkg::FRAC_W:0]     frac_s;
	logic signed [blr_pkg::ACC_W-1:0]    prod_i;
	logic signed [blr_pkg::ACC_W-1:0]    prod_q;
	logic signed [blr_pkg::ACC_W-1:0]    sum_i;
	logic signed [blr_pkg::ACC_W-1:0]    sum_q;

	logic                                m_tvalid_q;
	logic [blr_pkg::OUT_W-1:0]           i_out_q;
	logic [blr_pkg::OUT_W-1:0]           q_out_q;
	logic                                block_last_q;

	assign diff_i = {item.cur_i[blr_pkg::SAMPLE_W-1], item.cur_i}
		- {item.prev_i[blr_pkg::SAMPLE_W-1], item.prev_i};
	assign diff_q = {item.cur_q[blr_pkg::SAMPLE_W-1], item.cur_q}
		- {item.prev_q[blr_pkg::SAMPLE_W-1], item.prev_q};
	assign frac_s = {1'b0, item.frac};
	assign prod_i = blr_pkg::ACC_W'(diff_i) * blr_pkg::ACC_W'(frac_s);
	assign prod_q = blr_pkg::ACC_W'(diff_q) * blr_pkg::ACC_W'(frac_s);

	// prev scaled by 2048 plus the weighted step
	assign sum_i = {{2{item.prev_i[blr_pkg::SAMPLE_W-1]}}, item.prev_i,
		{blr_pkg::FRAC_W{1'b0}}} + prod_i;
	assign sum_q = {{2{item.prev_q[blr_pkg::SAMPLE_W-1]}}, item.prev_q,
		{blr_pkg::FRAC_W{1'b0}}} + prod_q;

	assign item_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (item_ready) begin
			m_tvalid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			i_out_q      <= sum_i[blr_pkg::OUT_W-1:0];
			q_out_q      <= sum_q[blr_pkg::OUT_W-1:0];
			block_last_q <= item.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = block_last_q;
	assign m_tdata  = {{(blr_pkg::M_TDATA_W - 2*blr_pkg::OUT_W){1'b0}}, q_out_q, i_out_q};

endmodule

FILE: tb/tb_block_linear_resampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_linear_resampler
// Streams random and corner-case I/Q samples into the resampler under random
// backpressure, predicts every interpolated output from an internal model of
// the block counters and history, and checks each output transaction in order.
// ----------------------------------------------------------------------------
module tb_block_linear_resampler;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		logic [blr_pkg::SAMPLE_W-1:0] i_s;
		logic [blr_pkg::SAMPLE_W-1:0] q_s;
		bit                           hold;
	} iq_item_t;

	typedef struct {
		logic signed [blr_pkg::OUT_W-1:0] i_v;
		logic signed [blr_pkg::OUT_W-1:0] q_v;
		logic                             last;
	} interp_out_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [blr_pkg::BLOCK_W-1:0]   cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [blr_pkg::S_TDATA_W-1:0] s_tdata = '0;    // i_sample, q_sample
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [blr_pkg::M_TDATA_W-1:0] m_tdata;         // i_out, q_out, zero pad
	logic                          m_tlast;         // block_last

	iq_item_t    pending_samples[$];
	interp_out_t expected_outputs[$];
	iq_item_t    tx_item;
	interp_out_t want;

	// model state
	logic [blr_pkg::BLOCK_W-1:0]         blk_len = blr_pkg::RESET_BLOCK;
	logic signed [blr_pkg::SAMPLE_W-1:0] hist_i = '0;
	logic signed [blr_pkg::SAMPLE_W-1:0] hist_q = '0;
	logic                                have_hist = 1'b0;
	logic [blr_pkg::BLOCK_W-1:0]         in_pos = '0;
	logic [blr_pkg::IDX_W-1:0]           out_num = '0;
	logic [blr_pkg::POS_W-1:0]           out_acc = '0;

	bit          s_fire = 1'b0;
	bit          tx_busy = 1'b0;
	int          tx_gap = 0;
	int          tx_calm = 0;
	int          rx_gap = 0;
	int          rx_calm = 0;
	int          errors = 0;
	int unsigned cycle_count = 0;

	block_linear_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [blr_pkg::OUT_W-1:0] mix(
			input logic signed [blr_pkg::SAMPLE_W-1:0] a,
			input logic signed [blr_pkg::SAMPLE_W-1:0] b,
			input logic [blr_pkg::FRAC_W-1:0] f);
		int v;
		v = int'(a) * (2048 - int'(f)) + int'(b) * int'(f);
		return v[blr_pkg::OUT_W-1:0];
	endfunction

	task automatic interpolate_sample(input logic signed [blr_pkg::SAMPLE_W-1:0] ci,
			input logic signed [blr_pkg::SAMPLE_W-1:0] cq);
		logic [blr_pkg::BLOCK_W-1:0] n;
		logic [blr_pkg::FRAC_W-1:0]  f;
		interp_out_t                 r;
		n = (blk_len < blr_pkg::MIN_BLOCK) ? blr_pkg::MIN_BLOCK : blk_len;
		if (!have_hist) begin
			// first sample only primes the history
			have_hist = 1'b1;
			in_pos = '0;
			out_num = '0;
			out_acc = '0;
		end else begin
			in_pos = in_pos + 1'b1;
			if (int'(out_acc >> blr_pkg::FRAC_W) + 1 == int'(in_pos)) begin
				f = out_acc[blr_pkg::FRAC_W-1:0];
				r.i_v = mix(hist_i, ci, f);
				r.q_v = mix(hist_q, cq, f);
				r.last = (out_num == blr_pkg::LAST_INDEX);
				expected_outputs.push_back(r);
				if (r.last) begin
					out_num = '0;
					out_acc = '0;
				end else begin
					out_num = out_num + 1'b1;
					out_acc = out_acc + n;
				end
			end
			// block end: last sample becomes sample 0 of the next block
			if (in_pos >= n) begin
				in_pos = '0;
				out_num = '0;
				out_acc = '0;
			end
		end
		hist_i = ci;
		hist_q = cq;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint exp_v);
		errors++;
		if (errors <= 100)
			$display("mismatch @%0d: %s got %0d want %0d", cycle_count, what, got, exp_v);
	endtask

	// mostly short gaps, a few long ones, and now and then a stretch with none
	task automatic next_gap(inout int calm, output int gap);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if (r < 3) begin
			calm = $urandom_range(30, 120);
			gap = 0;
		end else if (r < 55) begin
			gap = 0;
		end else if (r < 92) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 40);
		end
	endtask

	function automatic logic [blr_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return blr_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic queue_item(input logic [blr_pkg::SAMPLE_W-1:0] i_s,
			input logic [blr_pkg::SAMPLE_W-1:0] q_s, input bit hold);
		iq_item_t it;
		it.i_s = i_s;
		it.q_s = q_s;
		it.hold = hold;
		pending_samples.push_back(it);
	endtask

	task automatic queue_random(input int count);
		int hold_at;
		hold_at = $urandom_range(0, count - 1);
		for (int k = 0; k < count; k++)
			queue_item(rand_sample(), rand_sample(), k == hold_at);
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || tx_busy || expected_outputs.size() != 0)
			@(negedge clk);
		// samples that make no output may still be in flight
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_block_len(input logic [blr_pkg::BLOCK_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_fire)
				tx_busy = 1'b0;
			if (!tx_busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() != 0 &&
						!(pending_samples[0].hold && expected_outputs.size() != 0)) begin
					tx_item = pending_samples.pop_front();
					s_tdata <= {tx_item.q_s, tx_item.i_s};
					s_tvalid <= 1'b1;
					tx_busy = 1'b1;
					next_gap(tx_calm, tx_gap);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					next_gap(rx_calm, rx_gap);
			end
		end
	end

	// monitor: check outputs first, then predict from the accepted input
	always @(posedge clk) begin
		if (arst_n) begin
			s_fire = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch("unexpected output transaction",
						$signed(m_tdata[blr_pkg::OUT_W-1:0]), 0);
				end else begin
					want = expected_outputs.pop_front();
					if ($signed(m_tdata[blr_pkg::OUT_W-1:0]) !== want.i_v)
						report_mismatch("i_out", $signed(m_tdata[blr_pkg::OUT_W-1:0]),
							want.i_v);
					if ($signed(m_tdata[2*blr_pkg::OUT_W-1:blr_pkg::OUT_W]) !== want.q_v)
						report_mismatch("q_out",
							$signed(m_tdata[2*blr_pkg::OUT_W-1:blr_pkg::OUT_W]), want.q_v);
					if (m_tlast !== want.last)
						report_mismatch("block_last", m_tlast, want.last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				// register write restarts the block, history is kept
				blk_len = cfg_data;
				in_pos = '0;
				out_num = '0;
				out_acc = '0;
			end
			if (s_fire)
				interpolate_sample(s_tdata[blr_pkg::SAMPLE_W-1:0],
					s_tdata[blr_pkg::S_TDATA_W-1:blr_pkg::SAMPLE_W]);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset block length, first sample primes, then full-scale swings
		queue_item(16'h0000, 16'h0000, 1'b0);
		queue_item(16'h7FFF, 16'h8000, 1'b0);
		queue_item(16'h8000, 16'h7FFF, 1'b0);
		queue_item(16'h7FFF, 16'h7FFF, 1'b0);
		queue_item(16'h8000, 16'h8000, 1'b0);
		queue_item(16'h7FFF, 16'h8000, 1'b0);
		queue_item(16'h0000, 16'hFFFF, 1'b0);
		queue_item(16'hFFFF, 16'h0000, 1'b0);
		queue_item(16'h0001, 16'hFFFE, 1'b0);
		queue_item(16'h8000, 16'h8000, 1'b0);
		queue_item(16'h7FFF, 16'h7FFF, 1'b1);
		queue_item(16'h5555, 16'hAAAA, 1'b0);
		queue_item(16'hAAAA, 16'h5555, 1'b0);
		queue_item(16'h0000, 16'h0000, 1'b0);
		queue_item(16'h8000, 16'h7FFF, 1'b0);
		queue_item(16'h7FFF, 16'h8000, 1'b0);

		// too-small block length is clamped
		write_block_len(14'd1);
		queue_item(16'h7FFF, 16'h8000, 1'b0);
		queue_item(16'h8000, 16'h7FFF, 1'b0);
		queue_item(16'hFFFF, 16'h0001, 1'b0);
		queue_item(16'h0000, 16'h0000, 1'b0);

		write_block_len(14'd16383);
		queue_random(120);

		// fraction steps by one per output
		write_block_len(14'd2049);
		queue_random(250);

		write_block_len(blr_pkg::MIN_BLOCK);
		queue_random(120);

		write_block_len(blr_pkg::RESET_BLOCK);
		queue_random(120);

		write_block_len(blr_pkg::BLOCK_W'($urandom_range(2048, 16383)));
		queue_random(120);

		write_block_len(14'd0);
		queue_random(100);

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0 && expected_outputs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
